### hw/rtl/aeske_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-256 key expansion package
// Shared constants, control structs, the S-box table and the word functions.
// ----------------------------------------------------------------------------
package aeske_pkg;

    localparam int KEY_WORDS   = 8;
    localparam int SCHED_WORDS = 60;
    localparam int WORD_W      = 32;
    localparam int SLOT_W      = $clog2(KEY_WORDS);
    localparam int INDEX_W     = 6;

    localparam logic [7:0] RCON_INIT     = 8'h01;
    localparam logic [7:0] GF_POLY       = 8'h1b;
    localparam logic [2:0] PHASE_ROT_SUB = 3'd0;
    localparam logic [2:0] PHASE_SUB     = 3'd4;

    typedef struct packed {
        logic load;
        logic seed;
        logic shift;
    } t_cell_ctrl;

    typedef struct packed {
        logic step;
        logic restart;
    } t_gen_ctrl;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [WORD_W-1:0] sub_word(input logic [WORD_W-1:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [WORD_W-1:0] rot_word(input logic [WORD_W-1:0] w);
        return {w[23:0], w[31:24]};
    endfunction

    function automatic logic [7:0] gf_double(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
    endfunction

endpackage

### hw/rtl/aeske_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-256 key expansion window cell
// Holds one key word and one schedule word; the schedule word is seeded from
// the key word and then takes its neighbor's word.
// ----------------------------------------------------------------------------
module aeske_cell
    import aeske_pkg::*;
(
    input  logic              i_clk,
    input  t_cell_ctrl        i_ctrl,
    input  logic [WORD_W-1:0] i_load_word,
    input  logic [WORD_W-1:0] i_shift_word,
    output logic [WORD_W-1:0] o_word
);

    logic [WORD_W-1:0] r_key;
    logic [WORD_W-1:0] n_key;
    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;

    always_comb begin
        n_key  = r_key;
        n_word = r_word;
        if (i_ctrl.load) begin
            n_key = i_load_word;
        end
        if (i_ctrl.seed) begin
            n_word = n_key;
        end else if (i_ctrl.shift) begin
            n_word = i_shift_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

### hw/rtl/aeske_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-256 key expansion word generator
// Forms the next schedule word at the chain tail and keeps the round constant.
// ----------------------------------------------------------------------------
module aeske_gen
    import aeske_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_gen_ctrl         i_ctrl,
    input  logic [2:0]        i_phase,
    input  logic [WORD_W-1:0] i_old_word,
    input  logic [WORD_W-1:0] i_prev_word,
    output logic [WORD_W-1:0] o_word
);

    logic [7:0]        r_rcon;
    logic [7:0]        n_rcon;
    logic [WORD_W-1:0] w_temp;

    always_comb begin
        unique case (i_phase)
            PHASE_ROT_SUB: w_temp = sub_word(rot_word(i_prev_word)) ^ {r_rcon, 24'h000000};
            PHASE_SUB:     w_temp = sub_word(i_prev_word);
            default:       w_temp = i_prev_word;
        endcase
    end

    assign o_word = i_old_word ^ w_temp;

    always_comb begin
        n_rcon = r_rcon;
        if (i_ctrl.restart) begin
            n_rcon = RCON_INIT;
        end else if (i_ctrl.step && i_phase == PHASE_ROT_SUB) begin
            n_rcon = gf_double(r_rcon);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rcon <= RCON_INIT;
        end else begin
            r_rcon <= n_rcon;
        end
    end

endmodule

### hw/rtl/aes256_key_expansion_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-256 key expansion unit
// Latency: the first round key word is valid the cycle after the last key word.
// Throughput: one round key word per cycle while the consumer is ready; a key
// of 8 input words gives 60 round key words before the next key is taken.
// The single eight-cell window shifts once per emitted word and blocks input.
// Reset clears the control state and round constant; the window is unset.
// ----------------------------------------------------------------------------
module aes256_key_expansion_unit
    import aeske_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_key_valid,
    output logic               o_key_ready,
    input  logic [WORD_W-1:0]  i_key_word,
    input  logic               i_key_last,
    output logic               o_rk_valid,
    input  logic               i_rk_ready,
    output logic [WORD_W-1:0]  o_round_key_word,
    output logic [INDEX_W-1:0] o_word_index,
    output logic               o_last_word
);

    localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(SCHED_WORDS - 1);

    logic               r_busy;
    logic               n_busy;
    logic [SLOT_W-1:0]  r_load_count;
    logic [SLOT_W-1:0]  n_load_count;
    logic [INDEX_W-1:0] r_index;
    logic [INDEX_W-1:0] n_index;

    logic               w_in_acc;
    logic               w_out_acc;
    logic               w_done;
    logic [WORD_W-1:0]  w_cell_word [KEY_WORDS];
    logic [WORD_W-1:0]  w_gen_word;
    t_gen_ctrl          w_gen_ctrl;

    assign w_in_acc  = i_key_valid && !r_busy;
    assign w_out_acc = r_busy && i_rk_ready;
    assign w_done    = w_out_acc && r_index == LAST_INDEX;

    genvar k;
    generate
        for (k = 0; k < KEY_WORDS; k++) begin : g_cell
            t_cell_ctrl        w_ctrl;
            logic [WORD_W-1:0] w_shift_word;

            assign w_ctrl.load  = w_in_acc && r_load_count == SLOT_W'(k);
            assign w_ctrl.seed  = w_in_acc && i_key_last;
            assign w_ctrl.shift = w_out_acc;

            if (k == KEY_WORDS - 1) begin : g_tail
                assign w_shift_word = w_gen_word;
            end else begin : g_body
                assign w_shift_word = w_cell_word[k + 1];
            end

            aeske_cell u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (w_ctrl),
                .i_load_word  (i_key_word),
                .i_shift_word (w_shift_word),
                .o_word       (w_cell_word[k])
            );
        end
    endgenerate

    assign w_gen_ctrl.step    = w_out_acc;
    assign w_gen_ctrl.restart = w_done;

    aeske_gen u_gen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_gen_ctrl),
        .i_phase     (r_index[2:0]),
        .i_old_word  (w_cell_word[0]),
        .i_prev_word (w_cell_word[KEY_WORDS - 1]),
        .o_word      (w_gen_word)
    );

    always_comb begin
        n_busy       = r_busy;
        n_load_count = r_load_count;
        n_index      = r_index;
        if (w_in_acc) begin
            n_load_count = r_load_count + 1'b1;
            if (i_key_last) begin
                n_busy  = 1'b1;
                n_index = '0;
            end
        end
        if (w_out_acc) begin
            n_index = r_index + 1'b1;
        end
        if (w_done) begin
            n_busy       = 1'b0;
            n_load_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_load_count <= '0;
            r_index      <= '0;
        end else begin
            r_busy       <= n_busy;
            r_load_count <= n_load_count;
            r_index      <= n_index;
        end
    end

    assign o_key_ready      = !r_busy;
    assign o_rk_valid       = r_busy;
    assign o_round_key_word = w_cell_word[0];
    assign o_word_index     = r_index;
    assign o_last_word      = r_index == LAST_INDEX;

endmodule
